[design/rtpnack_pkg.sv]
// rtpnack_pkg: shared types, codes and helpers for the nack retransmit cache
// depends on nothing; imported by rtp_nack_retransmit_cache
`default_nettype none
package rtpnack_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_SLOT_COUNT = 2'd0;
   localparam logic [1:0] CSR_RESEND_PS  = 2'd1;
   localparam logic [1:0] CSR_DISCARD    = 2'd2;
   localparam logic [1:0] CSR_FLOOR_SEQ  = 2'd3;

   // request opcodes
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_NACK  = 1'b1;

   localparam logic [9:0]  DEFAULT_RING = 10'd128;
   localparam logic [15:0] DEFAULT_RATE = 16'd100;
   localparam logic [31:0] WINDOW_MS    = 32'd1000;
   localparam logic [10:0] MIN_PKT      = 11'd12;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ST_DIV,
      S_NK_CAND,
      S_NK_SCAN,
      S_NK_CMP,
      S_NK_ADD,
      S_SORT_I,
      S_SORT_V,
      S_SORT_CMP,
      S_SORT_PUT,
      S_OUT_RD,
      S_OUT_FLOOR,
      S_OUT_DIV,
      S_OUT_HIT,
      S_OUT_FIN
   } state_type;

   // wrap-aware order: a comes before b
   function automatic logic seq_before(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] d;
      d = a - b;
      return d[15];
   endfunction

endpackage
`default_nettype wire

[design/rtpnack_mod.sv]
// rtpnack_mod: 16-bit by 10-bit remainder unit, four quotient bits per cycle
// standalone; used by rtp_nack_retransmit_cache for slot index
`default_nettype none
module rtpnack_mod (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic [15:0] num,
   input  wire logic [9:0]  den,
   output logic             done,
   output logic [9:0]       rem
);

   logic [15:0] num_ff, num_in;
   logic [9:0]  rem_ff, rem_in;
   logic [9:0]  den_ff, den_in;
   logic [1:0]  step_ff, step_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [10:0] r;

   // four restoring steps per cycle
   always_comb begin
      r = {1'b0, rem_ff};
      for (int t = 0; t < 4; t++) begin
         r = {r[9:0], num_ff[15 - t]};
         if (r >= {1'b0, den_ff}) begin
            r = r - {1'b0, den_ff};
         end
      end
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         num_in  = {num_ff[11:0], 4'd0};
         rem_in  = r[9:0];
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

`ifndef SYNTHESIS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("remainder done held");
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      done_ff && den_ff != 10'd0 |-> rem_ff < den_ff) else $error("remainder out of range");
   a_run_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff) else $error("done while running");
`endif

endmodule
`default_nettype wire

[design/rtp_nack_retransmit_cache.sv]
// rtp_nack_retransmit_cache: packet record ring plus nack expansion, sort and resend pick
// depends on rtpnack_pkg and rtpnack_mod
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  request  | start / busy           | req_op, req_pkt_seq, req_pkt_len, req_nack_pid,
//           |                        | req_nack_blp, req_last_word, req_now_ms
//  result   | rsp_strobe (one cycle) | rsp_resend_valid/seq/slot/len, rsp_sent_count,
//           |                        | rsp_rate_limited, rsp_last
//  config   | csr_valid / csr_ready  | csr_index, csr_data
//
// a store runs the sequence number through the remainder unit for the slot index,
// then does one ring write; a bad-length store is taken without a write.
// a nack word scans the list entries for duplicates of each candidate on the
// single-port list memory; the final word adds an insertion sort and, per list entry,
// a remainder, a ring read and a rate check.
// after reset and after a slot count write a clearing pass over all RING_MAX slots runs
// with busy high. results cannot be stalled; one strobe per resend, or a single final
// beat when there is none.
`default_nettype none
module rtp_nack_retransmit_cache #(
   parameter int RING_MAX   = 512,
   parameter int MAX_EXPAND = 64,
   parameter int MAX_PKT    = 1500
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [15:0] req_pkt_seq,
   input  wire logic [10:0] req_pkt_len,
   input  wire logic [15:0] req_nack_pid,
   input  wire logic [15:0] req_nack_blp,
   input  wire logic        req_last_word,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_strobe,
   output logic             rsp_resend_valid,
   output logic [15:0]      rsp_resend_seq,
   output logic [8:0]       rsp_resend_slot,
   output logic [10:0]      rsp_resend_len,
   output logic [6:0]       rsp_sent_count,
   output logic             rsp_rate_limited,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import rtpnack_pkg::*;

   localparam int AW = (RING_MAX > 1) ? $clog2(RING_MAX) : 1;
   localparam int LW = (MAX_EXPAND > 1) ? $clog2(MAX_EXPAND) : 1;
   localparam int CW = $clog2(MAX_EXPAND + 1);

   state_type state_ff, state_in;

   // ring and list memories
   logic [26:0]   ring_mem [RING_MAX];
   logic [15:0]   list_mem [MAX_EXPAND];
   logic          ring_we, list_we;
   logic [AW-1:0] ring_waddr, ring_raddr;
   logic [26:0]   ring_wdata, ring_rd_ff;
   logic [LW-1:0] list_waddr, list_raddr;
   logic [15:0]   list_wdata, list_rd_ff;

   // configuration
   logic [9:0]  ring_ff, ring_in;
   logic [15:0] rps_ff, rps_in;
   logic        disc_ff, disc_in;
   logic [15:0] floor_ff, floor_in;

   // working registers
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [16:0]   mask_ff, mask_in;
   logic [15:0]   pid_ff, pid_in;
   logic [15:0]   cand_ff, cand_in;
   logic          lastw_ff, lastw_in;
   logic [31:0]   now_ff, now_in;
   logic [15:0]   seq_ff, seq_in;
   logic [10:0]   len_ff, len_in;
   logic [15:0]   v_ff, v_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [31:0]   wstart_ff, wstart_in;
   logic [15:0]   wcnt_ff, wcnt_in;
   logic          pend_v_ff, pend_v_in;
   logic [15:0]   pend_seq_ff, pend_seq_in;
   logic [8:0]    pend_slot_ff, pend_slot_in;
   logic [10:0]   pend_len_ff, pend_len_in;
   logic [6:0]    sent_ff, sent_in;
   logic          lim_ff, lim_in;

   // result registers
   logic        strobe_ff, strobe_in;
   logic        o_valid_ff, o_valid_in;
   logic [15:0] o_seq_ff, o_seq_in;
   logic [8:0]  o_slot_ff, o_slot_in;
   logic [10:0] o_len_ff, o_len_in;
   logic [6:0]  o_cnt_ff, o_cnt_in;
   logic        o_lim_ff, o_lim_in;
   logic        o_last_ff, o_last_in;

   // remainder unit
   logic        mod_go, mod_done;
   logic [15:0] mod_num;
   logic [9:0]  mod_rem;

   rtpnack_mod u_mod (
      .clock (clock),
      .reset (reset),
      .go    (mod_go),
      .num   (mod_num),
      .den   (ring_ff),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   // helpers
   logic [4:0]  pick_pos;
   logic [15:0] pick_seq;
   logic [12:0] ring_raw;
   logic [9:0]  ring_clamped;
   logic        win_new;
   logic [31:0] win_start_n;
   logic [15:0] win_cnt_n;
   logic [15:0] rate_cap;

   always_comb begin
      pick_pos = '0;
      for (int p = 0; p < 17; p++) begin
         if (mask_ff[p]) begin
            pick_pos = 5'(p);
         end
      end
      pick_seq = pid_ff + {11'd0, 5'd16 - pick_pos};
   end

   always_comb begin
      ring_raw = {3'd0, csr_data[9:0]};
      if (ring_raw == 13'd0) begin
         ring_raw = {3'd0, DEFAULT_RING};
      end
      if (ring_raw > 13'(RING_MAX)) begin
         ring_raw = 13'(RING_MAX);
      end
      ring_clamped = ring_raw[9:0];
   end

   // rate window as seen by the hit under test
   always_comb begin
      win_new     = (wstart_ff == 32'd0) || ((now_ff - wstart_ff) >= WINDOW_MS);
      win_start_n = win_new ? now_ff : wstart_ff;
      win_cnt_n   = win_new ? 16'd0 : wcnt_ff;
      rate_cap    = (rps_ff == 16'd0) ? DEFAULT_RATE : rps_ff;
   end

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      ring_in      = ring_ff;
      rps_in       = rps_ff;
      disc_in      = disc_ff;
      floor_in     = floor_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      mask_in      = mask_ff;
      pid_in       = pid_ff;
      cand_in      = cand_ff;
      lastw_in     = lastw_ff;
      now_in       = now_ff;
      seq_in       = seq_ff;
      len_in       = len_ff;
      v_in         = v_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      wstart_in    = wstart_ff;
      wcnt_in      = wcnt_ff;
      pend_v_in    = pend_v_ff;
      pend_seq_in  = pend_seq_ff;
      pend_slot_in = pend_slot_ff;
      pend_len_in  = pend_len_ff;
      sent_in      = sent_ff;
      lim_in       = lim_ff;
      strobe_in    = 1'b0;
      o_valid_in   = o_valid_ff;
      o_seq_in     = o_seq_ff;
      o_slot_in    = o_slot_ff;
      o_len_in     = o_len_ff;
      o_cnt_in     = o_cnt_ff;
      o_lim_in     = o_lim_ff;
      o_last_in    = o_last_ff;
      ring_we      = 1'b0;
      ring_waddr   = clr_ff;
      ring_wdata   = '0;
      ring_raddr   = AW'(mod_rem);
      list_we      = 1'b0;
      list_waddr   = LW'(cnt_ff);
      list_wdata   = cand_ff;
      list_raddr   = LW'(i_ff);
      mod_go       = 1'b0;
      mod_num      = req_pkt_seq;

      unique case (state_ff)
         // sweep every ring slot to empty
         S_CLEAR: begin
            ring_we    = 1'b1;
            ring_waddr = clr_ff;
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == AW'(RING_MAX - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               now_in = req_now_ms;
               if (req_op == OP_STORE) begin
                  seq_in = req_pkt_seq;
                  len_in = req_pkt_len;
                  if (req_pkt_len >= MIN_PKT && req_pkt_len <= 11'(MAX_PKT)) begin
                     mod_go   = 1'b1;
                     state_in = S_ST_DIV;
                  end
               end else begin
                  pid_in   = req_nack_pid;
                  mask_in  = {1'b1, req_nack_blp};
                  lastw_in = req_last_word;
                  state_in = S_NK_CAND;
               end
            end
         end
         S_ST_DIV: begin
            if (mod_done) begin
               ring_we    = 1'b1;
               ring_waddr = AW'(mod_rem);
               ring_wdata = {seq_ff, len_ff};
               state_in   = S_IDLE;
            end
         end
         // next candidate of this word, or wrap up the word
         S_NK_CAND: begin
            if (cnt_ff == CW'(MAX_EXPAND) || mask_ff == 17'd0) begin
               if (lastw_ff) begin
                  i_in     = CW'(1);
                  state_in = S_SORT_I;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               cand_in = pick_seq;
               mask_in = mask_ff & ~(17'd1 << pick_pos);
               i_in    = '0;
               state_in = (cnt_ff == '0) ? S_NK_ADD : S_NK_SCAN;
            end
         end
         S_NK_SCAN: begin
            list_raddr = LW'(i_ff);
            state_in   = S_NK_CMP;
         end
         // duplicate check against one stored entry
         S_NK_CMP: begin
            if (list_rd_ff == cand_ff) begin
               state_in = S_NK_CAND;
            end else if (CW'(i_ff + 1'b1) == cnt_ff) begin
               state_in = S_NK_ADD;
            end else begin
               i_in     = CW'(i_ff + 1'b1);
               state_in = S_NK_SCAN;
            end
         end
         S_NK_ADD: begin
            list_we    = 1'b1;
            list_waddr = LW'(cnt_ff);
            list_wdata = cand_ff;
            cnt_in     = CW'(cnt_ff + 1'b1);
            state_in   = S_NK_CAND;
         end
         // insertion sort, outer step
         S_SORT_I: begin
            list_raddr = LW'(i_ff);
            if (i_ff >= cnt_ff) begin
               i_in      = '0;
               pend_v_in = 1'b0;
               lim_in    = 1'b0;
               sent_in   = '0;
               state_in  = S_OUT_RD;
            end else begin
               state_in = S_SORT_V;
            end
         end
         S_SORT_V: begin
            v_in       = list_rd_ff;
            j_in       = i_ff;
            list_raddr = LW'(CW'(i_ff - 1'b1));
            state_in   = S_SORT_CMP;
         end
         // shift one entry up or place the value
         S_SORT_CMP: begin
            if (seq_before(v_ff, list_rd_ff)) begin
               list_we    = 1'b1;
               list_waddr = LW'(j_ff);
               list_wdata = list_rd_ff;
               j_in       = CW'(j_ff - 1'b1);
               list_raddr = LW'(CW'(j_ff - 2'd2));
               if (j_ff == CW'(1)) begin
                  state_in = S_SORT_PUT;
               end
            end else begin
               list_we    = 1'b1;
               list_waddr = LW'(j_ff);
               list_wdata = v_ff;
               i_in       = CW'(i_ff + 1'b1);
               state_in   = S_SORT_I;
            end
         end
         S_SORT_PUT: begin
            list_we    = 1'b1;
            list_waddr = LW'(j_ff);
            list_wdata = v_ff;
            i_in       = CW'(i_ff + 1'b1);
            state_in   = S_SORT_I;
         end
         // walk the sorted list
         S_OUT_RD: begin
            list_raddr = LW'(i_ff);
            state_in   = (i_ff == cnt_ff) ? S_OUT_FIN : S_OUT_FLOOR;
         end
         S_OUT_FLOOR: begin
            seq_in = list_rd_ff;
            if (disc_ff && seq_before(list_rd_ff, floor_ff)) begin
               i_in     = CW'(i_ff + 1'b1);
               state_in = S_OUT_RD;
            end else begin
               mod_go   = 1'b1;
               mod_num  = list_rd_ff;
               state_in = S_OUT_DIV;
            end
         end
         S_OUT_DIV: begin
            ring_raddr = AW'(mod_rem);
            if (mod_done) begin
               idx_in   = AW'(mod_rem);
               state_in = S_OUT_HIT;
            end
         end
         // cache check, rate check, emit the previous hit
         S_OUT_HIT: begin
            i_in = CW'(i_ff + 1'b1);
            state_in = S_OUT_RD;
            if (ring_rd_ff[10:0] != 11'd0 && ring_rd_ff[26:11] == seq_ff) begin
               wstart_in = win_start_n;
               if (win_cnt_n >= rate_cap) begin
                  wcnt_in  = win_cnt_n;
                  lim_in   = 1'b1;
                  state_in = S_OUT_FIN;
               end else begin
                  wcnt_in = win_cnt_n + 16'd1;
                  if (pend_v_ff) begin
                     strobe_in  = 1'b1;
                     o_valid_in = 1'b1;
                     o_seq_in   = pend_seq_ff;
                     o_slot_in  = pend_slot_ff;
                     o_len_in   = pend_len_ff;
                     o_cnt_in   = sent_ff;
                     o_lim_in   = 1'b0;
                     o_last_in  = 1'b0;
                  end
                  pend_v_in    = 1'b1;
                  pend_seq_in  = seq_ff;
                  pend_slot_in = 9'(idx_ff);
                  pend_len_in  = ring_rd_ff[10:0];
                  sent_in      = sent_ff + 7'd1;
               end
            end
         end
         // final beat of the message
         S_OUT_FIN: begin
            strobe_in  = 1'b1;
            o_valid_in = pend_v_ff;
            o_seq_in   = pend_v_ff ? pend_seq_ff : 16'd0;
            o_slot_in  = pend_v_ff ? pend_slot_ff : 9'd0;
            o_len_in   = pend_v_ff ? pend_len_ff : 11'd0;
            o_cnt_in   = pend_v_ff ? sent_ff : 7'd0;
            o_lim_in   = lim_ff;
            o_last_in  = 1'b1;
            cnt_in     = '0;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SLOT_COUNT: begin
               ring_in   = ring_clamped;
               wstart_in = '0;
               wcnt_in   = '0;
               floor_in  = '0;
               clr_in    = '0;
               state_in  = S_CLEAR;
            end
            CSR_RESEND_PS: rps_in   = csr_data;
            CSR_DISCARD:   disc_in  = csr_data[0];
            CSR_FLOOR_SEQ: floor_in = csr_data;
         endcase
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff   <= (RING_MAX < 128) ? 10'(RING_MAX) : DEFAULT_RING;
         rps_ff    <= DEFAULT_RATE;
         disc_ff   <= 1'b0;
         floor_ff  <= '0;
         cnt_ff    <= '0;
         clr_ff    <= '0;
         wstart_ff <= '0;
         wcnt_ff   <= '0;
         pend_v_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         ring_ff   <= ring_in;
         rps_ff    <= rps_in;
         disc_ff   <= disc_in;
         floor_ff  <= floor_in;
         cnt_ff    <= cnt_in;
         clr_ff    <= clr_in;
         wstart_ff <= wstart_in;
         wcnt_ff   <= wcnt_in;
         pend_v_ff <= pend_v_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      mask_ff      <= mask_in;
      pid_ff       <= pid_in;
      cand_ff      <= cand_in;
      lastw_ff     <= lastw_in;
      now_ff       <= now_in;
      seq_ff       <= seq_in;
      len_ff       <= len_in;
      v_ff         <= v_in;
      idx_ff       <= idx_in;
      pend_seq_ff  <= pend_seq_in;
      pend_slot_ff <= pend_slot_in;
      pend_len_ff  <= pend_len_in;
      sent_ff      <= sent_in;
      lim_ff       <= lim_in;
      o_valid_ff   <= o_valid_in;
      o_seq_ff     <= o_seq_in;
      o_slot_ff    <= o_slot_in;
      o_len_ff     <= o_len_in;
      o_cnt_ff     <= o_cnt_in;
      o_lim_ff     <= o_lim_in;
      o_last_ff    <= o_last_in;
   end

   // ring memory
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      ring_rd_ff <= ring_mem[ring_raddr];
   end

   // request list memory
   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_waddr] <= list_wdata;
      end
      list_rd_ff <= list_mem[list_raddr];
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_strobe       = strobe_ff;
   assign rsp_resend_valid = o_valid_ff;
   assign rsp_resend_seq   = o_seq_ff;
   assign rsp_resend_slot  = o_slot_ff;
   assign rsp_resend_len   = o_len_ff;
   assign rsp_sent_count   = o_cnt_ff;
   assign rsp_rate_limited = o_lim_ff;
   assign rsp_last         = o_last_ff;

`ifndef SYNTHESIS
   a_list_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_EXPAND)) else $error("request count overflow");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy) else $error("busy after final beat");
   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_resend_valid |-> rsp_sent_count != 7'd0)
      else $error("resend with zero count");
   a_limit_final: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_rate_limited |-> rsp_last) else $error("rate flag on inner beat");
`endif

endmodule
`default_nettype wire

[tb/rtp_nack_retransmit_cache_tb.sv]
// rtp_nack_retransmit_cache_tb: self-checking bench for the nack retransmit cache
// depends on rtpnack_pkg and rtp_nack_retransmit_cache; predicts resends from a local copy
// of the ring, nack list and rate window
`timescale 1ns / 100ps
`default_nettype none
module rtp_nack_retransmit_cache_tb;
   import rtpnack_pkg::*;

   localparam int RING_N   = 512;
   localparam int LIST_MAX = 64;
   localparam int PKT_MAX  = 1500;

   typedef struct packed {
      logic        op;
      logic [15:0] seq;
      logic [10:0] len;
      logic [15:0] pid;
      logic [15:0] blp;
      logic        lastw;
      logic [31:0] now;
   } nack_req_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] seq;
      logic [8:0]  slot;
      logic [10:0] len;
      logic [6:0]  cnt;
      logic        lim;
      logic        last;
   } resend_type;

   typedef struct packed {
      nack_req_type req;
      logic         typed;
      resend_type   want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic        req_op = 1'b0;
   logic [15:0] req_pkt_seq = '0;
   logic [10:0] req_pkt_len = '0;
   logic [15:0] req_nack_pid = '0;
   logic [15:0] req_nack_blp = '0;
   logic        req_last_word = 1'b0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_strobe, rsp_resend_valid, rsp_rate_limited, rsp_last;
   logic [15:0] rsp_resend_seq;
   logic [8:0]  rsp_resend_slot;
   logic [10:0] rsp_resend_len;
   logic [6:0]  rsp_sent_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   rtp_nack_retransmit_cache DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_pkt_seq(req_pkt_seq), .req_pkt_len(req_pkt_len),
      .req_nack_pid(req_nack_pid), .req_nack_blp(req_nack_blp),
      .req_last_word(req_last_word), .req_now_ms(req_now_ms),
      .rsp_strobe(rsp_strobe), .rsp_resend_valid(rsp_resend_valid),
      .rsp_resend_seq(rsp_resend_seq), .rsp_resend_slot(rsp_resend_slot),
      .rsp_resend_len(rsp_resend_len), .rsp_sent_count(rsp_sent_count),
      .rsp_rate_limited(rsp_rate_limited), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // local copy of the cache state
   logic [15:0] ring_seq [RING_N];
   logic [10:0] ring_len [RING_N];
   logic [15:0] nack_list [$];
   logic [31:0] win_start;
   logic [15:0] win_count;
   int unsigned cfg_ring;
   logic [15:0] cfg_rate, cfg_floor;
   logic        cfg_discard;

   resend_type pending_resends [$];
   resend_type step_out [$];
   int      errors = 0;
   bit      idle_on = 1'b0;
   logic [31:0] tnow;

   function automatic logic is_before(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] d;
      d = a - b;
      return d[15];
   endfunction

   task automatic list_add(input logic [15:0] s);
      if (nack_list.size() >= LIST_MAX) return;
      foreach (nack_list[i])
         if (nack_list[i] == s) return;
      nack_list.push_back(s);
   endtask

   // predicted resends of one request beat, left in step_out
   task automatic resend_predict(input nack_req_type r);
      int unsigned idx, sent, j;
      logic [15:0] v, s, cap;
      logic limited;
      resend_type o;
      step_out.delete();
      sent = 0;
      limited = 1'b0;
      if (r.op == OP_STORE) begin
         if (r.len >= MIN_PKT && r.len <= PKT_MAX) begin
            idx = r.seq % cfg_ring;
            ring_seq[idx] = r.seq;
            ring_len[idx] = r.len;
         end
         return;
      end
      if (nack_list.size() < LIST_MAX) begin
         list_add(r.pid);
         for (int b = 0; b < 16; b++)
            if (r.blp[15-b]) list_add(r.pid + 16'(1 + b));
      end
      if (!r.lastw) return;
      // wrap-aware insertion sort
      for (int i = 1; i < nack_list.size(); i++) begin
         v = nack_list[i];
         j = i;
         while (j > 0 && is_before(v, nack_list[j-1])) begin
            nack_list[j] = nack_list[j-1];
            j--;
         end
         nack_list[j] = v;
      end
      foreach (nack_list[i]) begin
         s = nack_list[i];
         if (cfg_discard && is_before(s, cfg_floor)) continue;
         idx = s % cfg_ring;
         if (ring_len[idx] == 0 || ring_seq[idx] != s) continue;
         if (win_start == 0 || (r.now - win_start) >= WINDOW_MS) begin
            win_start = r.now;
            win_count = 0;
         end
         cap = (cfg_rate != 0) ? cfg_rate : DEFAULT_RATE;
         if (win_count >= cap) begin
            limited = 1'b1;
            break;
         end
         win_count++;
         sent++;
         o = '0;
         o.valid = 1'b1;
         o.seq = s;
         o.slot = idx[8:0];
         o.len = ring_len[idx];
         o.cnt = sent[6:0];
         step_out.push_back(o);
      end
      nack_list.delete();
      if (step_out.size() == 0) step_out.push_back('0);
      o = step_out[step_out.size()-1];
      o.lim = limited;
      o.last = 1'b1;
      step_out[step_out.size()-1] = o;
   endtask

   // one request beat with optional idle gap ahead of it
   task automatic send_req(input nack_req_type r, input logic typed, input resend_type want);
      if (idle_on && $urandom_range(0, 99) < 33) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_op <= r.op;
      req_pkt_seq <= r.seq;
      req_pkt_len <= r.len;
      req_nack_pid <= r.pid;
      req_nack_blp <= r.blp;
      req_last_word <= r.lastw;
      req_now_ms <= r.now;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      resend_predict(r);
      if (typed && step_out.size() != 0) pending_resends.push_back(want);
      else foreach (step_out[i]) pending_resends.push_back(step_out[i]);
   endtask

   // wait until every resend is in and the block is idle
   task automatic drain();
      start <= 1'b0;
      while (pending_resends.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] data);
      int k;
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SLOT_COUNT: begin
            k = data[9:0];
            if (k == 0) k = DEFAULT_RING;
            if (k > RING_N) k = RING_N;
            cfg_ring = k;
            foreach (ring_len[i]) ring_len[i] = '0;
            win_start = '0;
            win_count = '0;
            cfg_floor = '0;
         end
         CSR_RESEND_PS: cfg_rate = data;
         CSR_DISCARD:   cfg_discard = data[0];
         CSR_FLOOR_SEQ: cfg_floor = data;
         default: ;
      endcase
   endtask

   function automatic dir_row_type mk_row(input logic op, input logic [15:0] seq,
                                          input logic [10:0] len, input logic [15:0] pid,
                                          input logic [15:0] blp, input logic lastw,
                                          input logic [31:0] now);
      dir_row_type d;
      d = '0;
      d.req.op = op;
      d.req.seq = seq;
      d.req.len = len;
      d.req.pid = pid;
      d.req.blp = blp;
      d.req.lastw = lastw;
      d.req.now = now;
      return d;
   endfunction

   function automatic nack_req_type rand_store(input logic [15:0] seq, input bit good);
      nack_req_type r;
      r = '0;
      r.op = OP_STORE;
      r.seq = seq;
      r.len = good ? 11'($urandom_range(MIN_PKT, PKT_MAX)) : 11'($urandom_range(0, 2047));
      r.pid = 16'($urandom);
      r.blp = 16'($urandom);
      r.now = tnow;
      return r;
   endfunction

   // result beat check
   always @(posedge clock) begin
      resend_type got, want;
      if (!reset && rsp_strobe) begin
         got = {rsp_resend_valid, rsp_resend_seq, rsp_resend_slot, rsp_resend_len,
                rsp_sent_count, rsp_rate_limited, rsp_last};
         if (pending_resends.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat v=%0d seq=%0d slot=%0d len=%0d cnt=%0d",
                     $time, got.valid, got.seq, got.slot, got.len, got.cnt,
                     " lim=%0d last=%0d", got.lim, got.last);
         end else begin
            want = pending_resends.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: mismatch expected v=%0d seq=%0d slot=%0d len=%0d cnt=%0d",
                        $time, want.valid, want.seq, want.slot, want.len, want.cnt,
                        " lim=%0d last=%0d", want.lim, want.last);
               $display("%0t:          actual   v=%0d seq=%0d slot=%0d len=%0d cnt=%0d",
                        $time, got.valid, got.seq, got.slot, got.len, got.cnt,
                        " lim=%0d last=%0d", got.lim, got.last);
            end
         end
      end
   end

   // run limit
   initial begin
      #200_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      dir_row_type dir_rows [$];
      dir_row_type d;
      nack_req_type r;
      logic [15:0] next_seq, base;
      int nwords, sel;
      int unsigned ring_w [5];
      logic [15:0] rate_w [5];
      logic        disc_w [5];
      logic [15:0] floor_o [5];

      ring_w  = '{32'h0001, 32'h0200, 32'hFFFF, 32'h0000, 32'h00C8};
      rate_w  = '{16'd0, 16'd1, 16'hFFFF, 16'd3, 16'd2};
      disc_w  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
      floor_o = '{16'd0, 16'd30, 16'h8000, 16'hFFFF, 16'd20};

      cfg_ring = DEFAULT_RING;
      cfg_rate = DEFAULT_RATE;
      cfg_discard = 1'b0;
      cfg_floor = '0;
      win_start = '0;
      win_count = '0;
      foreach (ring_len[i]) begin
         ring_len[i] = '0;
         ring_seq[i] = '0;
      end

      // directed rows
      d = mk_row(OP_NACK, 0, 0, 16'd7, 16'h0000, 1'b1, 32'd5);
      d.typed = 1'b1;
      d.want.last = 1'b1;
      dir_rows.push_back(d);
      dir_rows.push_back(mk_row(OP_STORE, 16'd0, 11'd11, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_STORE, 16'd0, 11'd12, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_STORE, 16'hFFFF, 11'd1500, 16'hFFFF, 16'hFFFF, 1, 0));
      dir_rows.push_back(mk_row(OP_STORE, 16'd1, 11'd1501, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_STORE, 16'd2, 11'd2047, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_STORE, 16'd3, 11'd0, 0, 0, 0, 0));
      d = mk_row(OP_NACK, 0, 0, 16'd0, 16'h0000, 1'b1, 32'd0);
      d.typed = 1'b1;
      d.want = '{valid: 1'b1, seq: 16'd0, slot: 9'd0, len: 11'd12, cnt: 7'd1,
                 lim: 1'b0, last: 1'b1};
      dir_rows.push_back(d);
      dir_rows.push_back(mk_row(OP_NACK, 0, 0, 16'hFFFF, 16'h8000, 1'b1, 32'd0));
      // four full words overflow the list
      dir_rows.push_back(mk_row(OP_NACK, 0, 0, 16'd1, 16'hFFFF, 1'b0, 32'd10));
      dir_rows.push_back(mk_row(OP_NACK, 0, 0, 16'd100, 16'hFFFF, 1'b0, 32'd10));
      dir_rows.push_back(mk_row(OP_NACK, 0, 0, 16'd200, 16'hFFFF, 1'b0, 32'd10));
      dir_rows.push_back(mk_row(OP_NACK, 0, 0, 16'hFFF0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
      d = mk_row(OP_NACK, 0, 0, 16'd2, 16'h0000, 1'b1, 32'd20);
      d.typed = 1'b1;
      d.want.last = 1'b1;
      dir_rows.push_back(d);
      dir_rows.push_back(mk_row(OP_NACK, 0, 0, 16'hFFF0, 16'h0001, 1'b0, 32'd1234));
      dir_rows.push_back(mk_row(OP_NACK, 0, 0, 16'd0, 16'h0000, 1'b1, 32'd1234));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      drain();

      // random phases, each under its own register setting
      tnow = $urandom;
      for (int p = 0; p < 5; p++) begin
         idle_on = (p != 0);
         base = 16'($urandom);
         next_seq = base;
         csr_write(CSR_SLOT_COUNT, ring_w[p][15:0] | (p == 2 ? 16'hFC00 : 16'h0000));
         csr_write(CSR_RESEND_PS, rate_w[p]);
         csr_write(CSR_DISCARD, {15'h7FFF & 15'($urandom), disc_w[p]});
         csr_write(CSR_FLOOR_SEQ, base + floor_o[p]);
         for (int n = 0; n < 38; n++) begin
            sel = $urandom_range(0, 99);
            tnow = tnow + $urandom_range(0, 400);
            if ($urandom_range(0, 29) == 0)
               tnow = ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom;
            if (sel < 55) begin
               send_req(rand_store(next_seq, 1'b1), 1'b0, '0);
               next_seq++;
            end else if (sel < 82) begin
               // well-formed message over recent sequence numbers
               nwords = $urandom_range(1, 3);
               for (int w = 0; w < nwords; w++) begin
                  r = '0;
                  r.op = OP_NACK;
                  r.pid = next_seq - 16'($urandom_range(1, 48));
                  r.blp = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                          16'($urandom) & 16'($urandom) & 16'($urandom);
                  r.lastw = (w == nwords - 1);
                  r.seq = 16'($urandom);
                  r.len = 11'($urandom);
                  r.now = tnow;
                  send_req(r, 1'b0, '0);
               end
            end else if (sel < 92) begin
               send_req(rand_store(16'($urandom), 1'b0), 1'b0, '0);
            end else begin
               r = '0;
               r.op = OP_NACK;
               r.pid = 16'($urandom);
               r.blp = 16'($urandom);
               r.lastw = 1'($urandom_range(0, 1));
               r.seq = 16'($urandom);
               r.len = 11'($urandom);
               r.now = tnow;
               send_req(r, 1'b0, '0);
            end
         end
         // close any open message so nothing is left in the list
         r = '0;
         r.op = OP_NACK;
         r.pid = next_seq - 16'd1;
         r.lastw = 1'b1;
         r.now = tnow;
         send_req(r, 1'b0, '0);
         drain();
      end

      repeat (50) @(posedge clock);
      if (errors == 0 && pending_resends.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
design/rtpnack_pkg.sv
design/rtpnack_mod.sv
design/rtp_nack_retransmit_cache.sv
tb/rtp_nack_retransmit_cache_tb.sv
